FILE: design/pss_pkg.sv
// ---------------------------------------------------------------------------
// pss_pkg - shared types and constants for per_instruction_stride_stats
// Field widths, table geometry, op codes and the per-entry statistics record.
// ---------------------------------------------------------------------------
package pss_pkg;

    localparam int SLOTS       = 64;
    localparam int DEPTH_BITS  = 16;
    localparam int TABLE_DEPTH = 2 * SLOTS;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam int ENTRY_W = 6;
    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 13;
    localparam int STAT_W  = 64;
    localparam int DEPTH_W = 16;
    localparam int NEST_W  = DEPTH_BITS;

    localparam int S_TDATA_W = ((ENTRY_W + ADDR_W + SIZE_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = ((DEPTH_W + 7 * STAT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_ENTER  = 2'd1,
        OP_EXIT   = 2'd2
    } op_t;

    localparam logic CFG_READ_EN  = 1'b0;
    localparam logic CFG_WRITE_EN = 1'b1;

    typedef struct packed {
        logic [STAT_W-1:0] count;
        logic [STAT_W-1:0] bytes;
        logic [STAT_W-1:0] last_addr;
        logic [STAT_W-1:0] last_stride;
        logic [STAT_W-1:0] repeats;
        logic [STAT_W-1:0] stride_sum;
        logic [STAT_W-1:0] low_addr;
        logic [STAT_W-1:0] high_addr;
    } stat_rec_t;

    localparam int REC_W = $bits(stat_rec_t);

    localparam stat_rec_t RESET_REC = '{
        count:       '0,
        bytes:       '0,
        last_addr:   '1,
        last_stride: '1,
        repeats:     '0,
        stride_sum:  '0,
        low_addr:    '1,
        high_addr:   '0
    };

endpackage

FILE: design/pss_ram.sv
// ---------------------------------------------------------------------------
// pss_ram - generic single write port, single read port RAM
// Read data is registered and holds while the read enable is low.
// ---------------------------------------------------------------------------
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pss_update.sv
// ---------------------------------------------------------------------------
// pss_update - statistics update for one access
// Adds size, forms and sums the stride, counts repeats, tracks bounds.
// ---------------------------------------------------------------------------
module pss_update (
    input  pss_pkg::stat_rec_t            rec_in,
    input  logic [pss_pkg::ADDR_W-1:0]    address,
    input  logic [pss_pkg::SIZE_W-1:0]    size,
    input  logic                          apply,
    output pss_pkg::stat_rec_t            rec_out
);
    import pss_pkg::*;

    logic [STAT_W-1:0] stride;

    assign stride = address - rec_in.last_addr;

    always_comb
    begin
        rec_out = rec_in;
        if (apply)
        begin
            rec_out.bytes = rec_in.bytes + STAT_W'(size);
            // first access of an entry forms no stride
            if (rec_in.count != '0)
            begin
                rec_out.stride_sum  = rec_in.stride_sum + stride;
                rec_out.last_stride = stride;
                if (stride == rec_in.last_stride)
                begin
                    rec_out.repeats = rec_in.repeats + STAT_W'(1);
                end
            end
            if (address < rec_in.low_addr)
            begin
                rec_out.low_addr = address;
            end
            if (address > rec_in.high_addr)
            begin
                rec_out.high_addr = address;
            end
            rec_out.last_addr = address;
            rec_out.count     = rec_in.count + STAT_W'(1);
        end
    end

endmodule

FILE: design/per_instruction_stride_stats.sv
// ---------------------------------------------------------------------------
// per_instruction_stride_stats - per-slot memory access stride statistics
// Read and write tables of per-instruction access counters, strides, bounds.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser carries op and is_write, s_tdata carries
//   entry, address and size. Each beat gives exactly one result beat on m_*:
//   m_tuser carries applied, m_tdata the depth and the entry's statistics.
//   Routine enter/exit beats move the nesting counter (saturating both ways);
//   access beats update the selected entry only when nesting is non-zero and
//   logging for that kind is enabled through cfg_we/cfg_addr/cfg_wdata.
//   Timing: the table read is issued on the accept edge; the update and the
//   table write happen when the update stage advances, which also loads the
//   output register. One beat per cycle is sustained while m_tready is high;
//   back-to-back hits on one entry are bypassed around the RAM.
//   Reset: per-entry valid bits clear at once, so no clearing pass is run
//   and s_tready is high straight out of reset.
//   Stall: the output register holds while m_tready is low; one more beat
//   waits in the update stage, then s_tready drops.
// ---------------------------------------------------------------------------
module per_instruction_stride_stats (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry[5:0], address[69:6], size[82:70], zero pad
    input  logic [pss_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0], is_write[2]
    input  logic [pss_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // depth[15:0], access_count[79:16], byte_total[143:80],
    // stride_sum[207:144], repeat_count[271:208], prev_stride[335:272],
    // lowest_address[399:336], highest_address[463:400]
    output logic [pss_pkg::M_TDATA_W-1:0]   m_tdata,
    // applied[0]
    output logic [pss_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic                            cfg_wdata
);
    import pss_pkg::*;

    logic                 s_fire;
    logic                 s1_adv;
    logic                 s1_fire;
    logic [ENTRY_W-1:0]   in_entry;
    logic [TBL_AW-1:0]    rd_idx;

    logic                 rd_en_reg;
    logic                 wr_en_reg;
    logic [NEST_W-1:0]    nest_reg;
    logic [NEST_W-1:0]    nest_next;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    logic                 s1_is_write_reg;
    logic                 s1_in_range_reg;
    logic [TBL_AW-1:0]    s1_idx_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [SIZE_W-1:0]    s1_size_reg;
    logic                 s1_hit_reg;
    logic                 s1_vld_reg;

    stat_rec_t            fwd_rec_reg;
    logic [REC_W-1:0]     ram_rdata;
    stat_rec_t            cur_rec;
    stat_rec_t            upd_rec;
    logic                 kind_en;
    logic                 apply;
    logic                 ram_we;

    logic                 out_valid_reg;
    logic                 out_applied_reg;
    logic [DEPTH_W-1:0]   out_depth_reg;
    stat_rec_t            out_rec_reg;

    assign s1_adv   = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;

    assign in_entry = s_tdata[ENTRY_W-1:0];
    assign rd_idx   = (s_tuser[2] ? TBL_AW'(SLOTS) : '0) + TBL_AW'(in_entry);

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_reg <= 1'b1;
            wr_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_READ_EN:  rd_en_reg <= cfg_wdata;
                CFG_WRITE_EN: wr_en_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    pss_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (upd_rec),
        .re    (s_fire),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_op_reg       <= s_tuser[1:0];
            s1_is_write_reg <= s_tuser[2];
            s1_in_range_reg <= (32'(in_entry) < SLOTS);
            s1_idx_reg      <= rd_idx;
            s1_addr_reg     <= s_tdata[ENTRY_W +: ADDR_W];
            s1_size_reg     <= s_tdata[ENTRY_W + ADDR_W +: SIZE_W];
            // the RAM read misses a write to the same entry on this edge
            s1_hit_reg      <= ram_we && (s1_idx_reg == rd_idx);
            s1_vld_reg      <= valid_reg[rd_idx];
        end
        if (ram_we)
        begin
            fwd_rec_reg <= upd_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[s1_idx_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        if (s1_hit_reg)
        begin
            cur_rec = fwd_rec_reg;
        end
        else if (s1_vld_reg)
        begin
            cur_rec = stat_rec_t'(ram_rdata);
        end
        else
        begin
            cur_rec = RESET_REC;
        end
    end

    assign kind_en = s1_is_write_reg ? wr_en_reg : rd_en_reg;

    always_comb
    begin
        nest_next = nest_reg;
        apply     = 1'b0;
        case (op_t'(s1_op_reg))
            OP_ACCESS:
            begin
                apply = s1_in_range_reg && kind_en && (nest_reg != '0);
            end
            OP_ENTER:
            begin
                if (nest_reg != '1)
                begin
                    nest_next = nest_reg + NEST_W'(1);
                end
            end
            OP_EXIT:
            begin
                if (nest_reg != '0)
                begin
                    nest_next = nest_reg - NEST_W'(1);
                end
            end
            default: ;
        endcase
    end

    pss_update u_update (
        .rec_in  (cur_rec),
        .address (s1_addr_reg),
        .size    (s1_size_reg),
        .apply   (apply),
        .rec_out (upd_rec)
    );

    assign ram_we = s1_fire && apply;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nest_reg <= '0;
        end
        else if (s1_fire)
        begin
            nest_reg <= nest_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_applied_reg <= apply;
            out_depth_reg   <= DEPTH_W'(nest_next);
            out_rec_reg     <= s1_in_range_reg ? upd_rec : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_applied_reg;
    assign m_tdata  = {out_rec_reg.high_addr, out_rec_reg.low_addr,
                       out_rec_reg.last_stride, out_rec_reg.repeats,
                       out_rec_reg.stride_sum, out_rec_reg.bytes,
                       out_rec_reg.count, out_depth_reg};

`ifndef SYNTHESIS
    a_applied_needs_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (out_depth_reg != '0))
        else $error("applied result with zero nesting depth");

    a_applied_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (out_rec_reg.count != '0))
        else $error("applied result with zero access count");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(s1_idx_reg)])
        else $error("table write did not mark entry valid");

    a_nest_moves_on_event: assert property (@(posedge clk) disable iff (!rst_n)
        (nest_reg != $past(nest_reg)) |-> $past(s1_fire))
        else $error("nesting count changed without an event");

    a_no_write_on_non_access: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s1_op_reg == OP_ACCESS))
        else $error("table write on a routine event");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - testbench for per_instruction_stride_stats
// Streams routine enter/exit and access beats into the table, predicts each
// result beat from a local copy of the read/write tables and the nesting
// counter, and compares every output field. Covers depth saturation at zero,
// log enables, back-pressure and random strided access streams.
// ---------------------------------------------------------------------------
module tb;
    import pss_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int IDLE_LIMIT         = 2000;
    localparam int HOLD_AT            = 300;
    localparam int HOLD_CYCLES        = 80;
    localparam int NEST_SWEEP         = 8;
    localparam int PHASE_ITEMS        = 160;

    typedef struct packed {
        logic               applied;
        logic [DEPTH_W-1:0] depth;
        logic [STAT_W-1:0]  access_count;
        logic [STAT_W-1:0]  byte_total;
        logic [STAT_W-1:0]  stride_sum;
        logic [STAT_W-1:0]  repeat_count;
        logic [STAT_W-1:0]  prev_stride;
        logic [STAT_W-1:0]  lowest_address;
        logic [STAT_W-1:0]  highest_address;
    } entry_stats_t;

    class stride_scoreboard;
        stat_rec_t         tbl [TABLE_DEPTH];
        logic [NEST_W-1:0] nesting;
        logic              read_en;
        logic              write_en;
        entry_stats_t      pending_stats [$];
        int                mismatches;

        function new();
            foreach (tbl[i])
                tbl[i] = RESET_REC;
            nesting    = '0;
            read_en    = 1'b1;
            write_en   = 1'b1;
            mismatches = 0;
        endfunction

        function void write_cfg(logic idx, logic val);
            if (idx == CFG_READ_EN)
                read_en = val;
            else
                write_en = val;
        endfunction

        function entry_stats_t predict_event(logic [1:0] op, logic wr,
                                             logic [ENTRY_W-1:0] entry,
                                             logic [ADDR_W-1:0] addr,
                                             logic [SIZE_W-1:0] size);
            entry_stats_t      r;
            stat_rec_t         rec;
            int                k;
            logic              en;
            logic [STAT_W-1:0] stride;
            r = '0;
            k = int'(wr) * SLOTS + int'(entry);
            case (op)
                OP_ENTER:
                    if (nesting != '1)
                        nesting = nesting + 1'b1;
                OP_EXIT:
                    if (nesting != '0)
                        nesting = nesting - 1'b1;
                OP_ACCESS:
                begin
                    en = wr ? write_en : read_en;
                    if (int'(entry) < SLOTS && en && nesting != '0)
                    begin
                        rec = tbl[k];
                        rec.bytes = rec.bytes + STAT_W'(size);
                        // no stride on the first access of an entry
                        if (rec.count != '0)
                        begin
                            stride = addr - rec.last_addr;
                            rec.stride_sum = rec.stride_sum + stride;
                            if (stride == rec.last_stride)
                                rec.repeats = rec.repeats + 1'b1;
                            rec.last_stride = stride;
                        end
                        if (addr < rec.low_addr)
                            rec.low_addr = addr;
                        if (addr > rec.high_addr)
                            rec.high_addr = addr;
                        rec.last_addr = addr;
                        rec.count = rec.count + 1'b1;
                        tbl[k] = rec;
                        r.applied = 1'b1;
                    end
                end
                default: ;
            endcase
            r.depth = DEPTH_W'(nesting);
            if (int'(entry) < SLOTS)
            begin
                r.access_count    = tbl[k].count;
                r.byte_total      = tbl[k].bytes;
                r.stride_sum      = tbl[k].stride_sum;
                r.repeat_count    = tbl[k].repeats;
                r.prev_stride     = tbl[k].last_stride;
                r.lowest_address  = tbl[k].low_addr;
                r.highest_address = tbl[k].high_addr;
            end
            return r;
        endfunction

        function void note_event(logic [S_TUSER_W-1:0] user, logic [S_TDATA_W-1:0] data);
            entry_stats_t s;
            s = predict_event(user[1:0], user[2],
                              data[ENTRY_W-1:0],
                              data[ENTRY_W +: ADDR_W],
                              data[ENTRY_W+ADDR_W +: SIZE_W]);
            pending_stats = {pending_stats, s};
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [STAT_W-1:0] exp, logic [STAT_W-1:0] got);
            if (exp !== got)
                report_mismatch($sformatf("%s expected %h got %h", name, exp, got));
        endtask

        task check_result(logic [M_TUSER_W-1:0] user, logic [M_TDATA_W-1:0] data);
            entry_stats_t exp;
            if (pending_stats.size() == 0)
            begin
                report_mismatch("result beat with nothing pending");
                return;
            end
            exp = pending_stats.pop_front();
            check_field("applied", STAT_W'(exp.applied), STAT_W'(user[0]));
            check_field("depth", STAT_W'(exp.depth), STAT_W'(data[DEPTH_W-1:0]));
            check_field("access_count", exp.access_count, data[DEPTH_W + 0*STAT_W +: STAT_W]);
            check_field("byte_total", exp.byte_total, data[DEPTH_W + 1*STAT_W +: STAT_W]);
            check_field("stride_sum", exp.stride_sum, data[DEPTH_W + 2*STAT_W +: STAT_W]);
            check_field("repeat_count", exp.repeat_count, data[DEPTH_W + 3*STAT_W +: STAT_W]);
            check_field("prev_stride", exp.prev_stride, data[DEPTH_W + 4*STAT_W +: STAT_W]);
            check_field("lowest_address", exp.lowest_address,
                        data[DEPTH_W + 5*STAT_W +: STAT_W]);
            check_field("highest_address", exp.highest_address,
                        data[DEPTH_W + 6*STAT_W +: STAT_W]);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // entry, address, size, zero pad
    logic [S_TUSER_W-1:0] s_tuser;    // op, is_write
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // depth, access_count, byte_total, stride_sum,
                                      // repeat_count, prev_stride, lowest_address,
                                      // highest_address
    logic [M_TUSER_W-1:0] m_tuser;    // applied
    logic                 cfg_we;
    logic                 cfg_addr;
    logic                 cfg_wdata;

    stride_scoreboard  sb;
    bit                fast_mode;
    int                stall_cycles;
    int                nest_level;
    logic [STAT_W-1:0] stream_addr   [TABLE_DEPTH];
    logic [STAT_W-1:0] stream_stride [TABLE_DEPTH];

    per_instruction_stride_stats dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // beats are sampled on the edge, before any of this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_event(s_tuser, s_tdata);
            if (cfg_we)
                sb.write_cfg(cfg_addr, cfg_wdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result sink: random holds per beat, plus one long hold to back up the pipe
    initial
    begin
        int gap;
        int n;
        m_tready <= 1'b0;
        n = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (n == HOLD_AT)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = fast_mode ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            n++;
        end
    end

    task automatic send_beat(logic [1:0] op, logic wr, logic [ENTRY_W-1:0] entry,
                             logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {wr, op};
        s_tdata  <= S_TDATA_W'({size, addr, entry});
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_noise(logic [1:0] op);
        send_beat(op, 1'($urandom_range(0, 1)), ENTRY_W'($urandom_range(0, 63)),
                  {$urandom, $urandom}, SIZE_W'($urandom_range(0, 8191)));
    endtask

    task automatic configure(logic rd, logic wr);
        s_tvalid <= 1'b0;
        // let the last accepted beat reach the scoreboard first
        @(posedge clk);
        while (sb.pending_stats.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_READ_EN;
        cfg_wdata <= rd;
        @(posedge clk);
        cfg_addr  <= CFG_WRITE_EN;
        cfg_wdata <= wr;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly strided streams on a few hot slots so strides repeat
    task automatic send_random_access();
        logic              wr;
        logic [5:0]        e;
        int                k;
        logic [STAT_W-1:0] a;
        int                pick;
        wr = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
        begin
            e = 6'($urandom_range(0, 7));
            if (e > 3)
                e = e + 6'd56;
        end
        else
            e = 6'($urandom_range(0, 63));
        k = int'(wr) * SLOTS + int'(e);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 5))
                0: stream_stride[k] = 64'd1;
                1: stream_stride[k] = 64'd8;
                2: stream_stride[k] = 64'd64;
                3: stream_stride[k] = -64'sd8;
                4: stream_stride[k] = -64'sd4096;
                default: stream_stride[k] = {$urandom, $urandom};
            endcase
        end
        if (pick <= 7)
            a = stream_addr[k] + stream_stride[k];
        else
            a = {$urandom, $urandom};
        stream_addr[k] = a;
        send_beat(OP_ACCESS, wr, e, a, SIZE_W'($urandom_range(0, 8191)));
    endtask

    task automatic run_random_phase(int items);
        int roll;
        for (int i = 0; i < items; i++)
        begin
            roll = $urandom_range(0, 99);
            if (nest_level == 0 ? roll < 60 : roll < 6)
            begin
                send_noise(OP_ENTER);
                nest_level++;
            end
            else if (roll < 12)
            begin
                send_noise(OP_EXIT);
                if (nest_level > 0)
                    nest_level--;
            end
            else if (roll < 15)
                send_noise(OP_UNUSED);
            else
                send_random_access();
        end
    endtask

    initial
    begin
        sb           = new();
        fast_mode    = 1'b0;
        nest_level   = 0;
        foreach (stream_addr[i])
        begin
            stream_addr[i]   = {$urandom, $urandom};
            stream_stride[i] = 64'd8;
        end
        rst_n     = 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: depth floor, first access, strides, wraps, unused op
        send_beat(OP_ACCESS, 1'b0, 6'd0, 64'h1000, 13'd4);
        send_beat(OP_EXIT, 1'b0, 6'd0, 64'h0, 13'd0);
        send_beat(OP_ENTER, 1'b0, 6'd0, 64'h0, 13'd0);
        send_beat(OP_ACCESS, 1'b0, 6'd0, 64'h1000, 13'd0);
        send_beat(OP_ACCESS, 1'b0, 6'd0, 64'h1040, 13'd4096);
        send_beat(OP_ACCESS, 1'b0, 6'd0, 64'h1080, 13'h1FFF);
        send_beat(OP_ACCESS, 1'b0, 6'd0, 64'h1000, 13'd1);
        send_beat(OP_ACCESS, 1'b1, 6'd63, '1, 13'd1);
        send_beat(OP_ACCESS, 1'b1, 6'd63, 64'h0, 13'd2);
        send_beat(OP_ACCESS, 1'b1, 6'd63, 64'h8000_0000_0000_0000, 13'd3);
        send_beat(OP_UNUSED, 1'b1, 6'd63, '1, '1);
        send_beat(OP_ENTER, 1'b1, 6'd63, '1, '1);
        send_beat(OP_EXIT, 1'b0, 6'd0, 64'h0, 13'd0);
        send_beat(OP_ACCESS, 1'b0, 6'd63, 64'h5555_5555_5555_5555, 13'h1555);
        send_beat(OP_ACCESS, 1'b0, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA, 13'h0AAA);
        send_beat(OP_ACCESS, 1'b0, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 13'h0AAA);
        send_beat(OP_ACCESS, 1'b1, 6'd42, 64'h0123_4567_89AB_CDEF, 13'h1000);
        configure(1'b0, 1'b0);
        send_beat(OP_ACCESS, 1'b0, 6'd0, 64'h2000, 13'd8);
        send_beat(OP_ACCESS, 1'b1, 6'd63, 64'h2000, 13'd8);
        nest_level = 1;

        configure(1'b1, 1'b1);
        fast_mode = 1'b1;
        run_random_phase(PHASE_ITEMS);
        fast_mode = 1'b0;
        configure(1'b0, 1'b1);
        run_random_phase(PHASE_ITEMS);
        configure(1'b1, 1'b0);
        run_random_phase(PHASE_ITEMS);
        configure(1'b0, 1'b0);
        run_random_phase(PHASE_ITEMS);
        configure(1'b1, 1'b1);
        run_random_phase(PHASE_ITEMS);

        // short enter run, accesses around it, then an exit run past it
        fast_mode = 1'b1;
        for (int i = 0; i < NEST_SWEEP; i++)
            send_beat(OP_ENTER, 1'b0, 6'd5, 64'h0, 13'd0);
        send_beat(OP_ACCESS, 1'b0, 6'd5, 64'h4000, 13'd16);
        send_beat(OP_ENTER, 1'b1, 6'd5, 64'h0, 13'd0);
        for (int i = 0; i < NEST_SWEEP; i++)
            send_beat(OP_EXIT, 1'b0, 6'd5, 64'h0, 13'd0);
        send_beat(OP_EXIT, 1'b0, 6'd5, 64'h0, 13'd0);
        send_beat(OP_ACCESS, 1'b0, 6'd5, 64'h4010, 13'd16);
        fast_mode = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_stats.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
